### hdl/fixed_point_trig_unit_top_defines.svh
// ----------------------------------------------------------------------------
// fixed_point_trig_unit_top_defines
// assertion macros shared by the trig unit modules
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_TRIG_UNIT_TOP_DEFINES_SVH
`define FIXED_POINT_TRIG_UNIT_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FTU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define FTU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/ftu_pkg.sv
// ----------------------------------------------------------------------------
// ftu_pkg
// function codes, lookup tables and shared types of the trig unit
// ----------------------------------------------------------------------------
package ftu_pkg;

	localparam logic [2:0] FN_SIN  = 3'd0;
	localparam logic [2:0] FN_COS  = 3'd1;
	localparam logic [2:0] FN_ASIN = 3'd2;
	localparam logic [2:0] FN_ACOS = 3'd3;
	localparam logic [2:0] FN_ATAN = 3'd4;

	// one quotient bit per divider stage
	localparam int DIV_STAGES = 16;

	typedef struct packed {
		logic [2:0]  func;
		logic [15:0] arg;
		logic [2:0]  code;
		logic        special;
		logic [15:0] spec_val;
	} ftu_item_t;

	localparam logic [15:0] OCT_BASE [8] = '{
		16'hC000, 16'hC000, 16'h4000, 16'h4000, 16'h8000, 16'h0000, 16'h8000, 16'h0000
	};
	localparam logic [7:0] OCT_SUB = 8'b0110_1001;

	localparam logic [15:0] SINE_Q [65] = '{
		16'h0000, 16'h0324, 16'h0647, 16'h096A, 16'h0C8B, 16'h0FAB, 16'h12C7, 16'h15E1,
		16'h18F8, 16'h1C0B, 16'h1F19, 16'h2223, 16'h2527, 16'h2826, 16'h2B1E, 16'h2E10,
		16'h30FB, 16'h33DE, 16'h36B9, 16'h398C, 16'h3C56, 16'h3F16, 16'h41CD, 16'h447A,
		16'h471C, 16'h49B3, 16'h4C3F, 16'h4EBF, 16'h5133, 16'h539A, 16'h55F4, 16'h5842,
		16'h5A81, 16'h5CB3, 16'h5ED6, 16'h60EB, 16'h62F1, 16'h64E7, 16'h66CE, 16'h68A5,
		16'h6A6C, 16'h6C23, 16'h6DC9, 16'h6F5E, 16'h70E1, 16'h7254, 16'h73B5, 16'h7503,
		16'h7640, 16'h776B, 16'h7883, 16'h7989, 16'h7A7C, 16'h7B5C, 16'h7C29, 16'h7CE2,
		16'h7D89, 16'h7E1C, 16'h7E9C, 16'h7F08, 16'h7F61, 16'h7FA6, 16'h7FD7, 16'h7FF5,
		16'h7FFF
	};

	localparam logic [15:0] ASIN_ROM [257] = '{
		16'hC001, 16'hC519, 16'hC737, 16'hC8D7, 16'hCA37, 16'hCB6D, 16'hCC87, 16'hCD8A,
		16'hCE7C, 16'hCF5F, 16'hD037, 16'hD104, 16'hD1C9, 16'hD286, 16'hD33C, 16'hD3ED,
		16'hD498, 16'hD53E, 16'hD5DF, 16'hD67C, 16'hD716, 16'hD7AC, 16'hD83F, 16'hD8CF,
		16'hD95C, 16'hD9E7, 16'hDA6F, 16'hDAF4, 16'hDB78, 16'hDBF9, 16'hDC79, 16'hDCF7,
		16'hDD73, 16'hDDED, 16'hDE66, 16'hDEDD, 16'hDF53, 16'hDFC8, 16'hE03B, 16'hE0AD,
		16'hE11E, 16'hE18D, 16'hE1FC, 16'hE26A, 16'hE2D6, 16'hE342, 16'hE3AC, 16'hE416,
		16'hE47F, 16'hE4E7, 16'hE54E, 16'hE5B4, 16'hE61A, 16'hE67F, 16'hE6E3, 16'hE746,
		16'hE7A9, 16'hE80C, 16'hE86D, 16'hE8CE, 16'hE92F, 16'hE98F, 16'hE9EE, 16'hEA4D,
		16'hEAAB, 16'hEB09, 16'hEB66, 16'hEBC3, 16'hEC20, 16'hEC7C, 16'hECD7, 16'hED33,
		16'hED8D, 16'hEDE8, 16'hEE42, 16'hEE9C, 16'hEEF5, 16'hEF4E, 16'hEFA7, 16'hEFFF,
		16'hF057, 16'hF0AF, 16'hF106, 16'hF15D, 16'hF1B4, 16'hF20B, 16'hF261, 16'hF2B8,
		16'hF30D, 16'hF363, 16'hF3B9, 16'hF40E, 16'hF463, 16'hF4B8, 16'hF50C, 16'hF561,
		16'hF5B5, 16'hF609, 16'hF65D, 16'hF6B1, 16'hF704, 16'hF758, 16'hF7AB, 16'hF7FE,
		16'hF851, 16'hF8A4, 16'hF8F7, 16'hF949, 16'hF99C, 16'hF9EE, 16'hFA41, 16'hFA93,
		16'hFAE5, 16'hFB37, 16'hFB89, 16'hFBDB, 16'hFC2D, 16'hFC7F, 16'hFCD1, 16'hFD23,
		16'hFD74, 16'hFDC6, 16'hFE17, 16'hFE69, 16'hFEBA, 16'hFF0C, 16'hFF5E, 16'hFFAF,
		16'h0000, 16'h0051, 16'h00A2, 16'h00F4, 16'h0146, 16'h0197, 16'h01E9, 16'h023A,
		16'h028C, 16'h02DD, 16'h032F, 16'h0381, 16'h03D3, 16'h0425, 16'h0477, 16'h04C9,
		16'h051B, 16'h056D, 16'h05BF, 16'h0612, 16'h0664, 16'h06B7, 16'h0709, 16'h075C,
		16'h07AF, 16'h0802, 16'h0855, 16'h08A8, 16'h08FC, 16'h094F, 16'h09A3, 16'h09F7,
		16'h0A4B, 16'h0A9F, 16'h0AF4, 16'h0B48, 16'h0B9D, 16'h0BF2, 16'h0C47, 16'h0C9D,
		16'h0CF3, 16'h0D48, 16'h0D9F, 16'h0DF5, 16'h0E4C, 16'h0EA3, 16'h0EFA, 16'h0F51,
		16'h0FA9, 16'h1001, 16'h1059, 16'h10B2, 16'h110B, 16'h1164, 16'h11BE, 16'h1218,
		16'h1273, 16'h12CD, 16'h1329, 16'h1384, 16'h13E0, 16'h143D, 16'h149A, 16'h14F7,
		16'h1555, 16'h15B3, 16'h1612, 16'h1671, 16'h16D1, 16'h1732, 16'h1793, 16'h17F4,
		16'h1857, 16'h18BA, 16'h191D, 16'h1981, 16'h19E6, 16'h1A4C, 16'h1AB2, 16'h1B19,
		16'h1B81, 16'h1BEA, 16'h1C54, 16'h1CBE, 16'h1D2A, 16'h1D96, 16'h1E04, 16'h1E73,
		16'h1EE2, 16'h1F53, 16'h1FC5, 16'h2038, 16'h20AD, 16'h2123, 16'h219A, 16'h2213,
		16'h228D, 16'h2309, 16'h2387, 16'h2407, 16'h2488, 16'h250C, 16'h2591, 16'h2619,
		16'h26A4, 16'h2731, 16'h27C1, 16'h2854, 16'h28EA, 16'h2984, 16'h2A21, 16'h2AC2,
		16'h2B68, 16'h2C13, 16'h2CC4, 16'h2D7A, 16'h2E37, 16'h2EFC, 16'h2FC9, 16'h30A1,
		16'h3184, 16'h3276, 16'h3379, 16'h3493, 16'h35C9, 16'h3729, 16'h38C9, 16'h3AE7,
		16'h4000
	};

	localparam logic [15:0] ACOS_ROM [257] = '{
		16'h7FFF, 16'h7AE7, 16'h78C9, 16'h7729, 16'h75C9, 16'h7493, 16'h7379, 16'h7276,
		16'h7184, 16'h70A1, 16'h6FC9, 16'h6EFC, 16'h6E37, 16'h6D7A, 16'h6CC4, 16'h6C13,
		16'h6B68, 16'h6AC2, 16'h6A21, 16'h6984, 16'h68EA, 16'h6854, 16'h67C1, 16'h6731,
		16'h66A4, 16'h6619, 16'h6591, 16'h650C, 16'h6488, 16'h6407, 16'h6387, 16'h6309,
		16'h628D, 16'h6213, 16'h619A, 16'h6123, 16'h60AD, 16'h6038, 16'h5FC5, 16'h5F53,
		16'h5EE2, 16'h5E73, 16'h5E04, 16'h5D96, 16'h5D2A, 16'h5CBE, 16'h5C54, 16'h5BEA,
		16'h5B81, 16'h5B19, 16'h5AB2, 16'h5A4C, 16'h59E6, 16'h5981, 16'h591D, 16'h58BA,
		16'h5857, 16'h57F4, 16'h5793, 16'h5732, 16'h56D1, 16'h5671, 16'h5612, 16'h55B3,
		16'h5555, 16'h54F7, 16'h549A, 16'h543D, 16'h53E0, 16'h5384, 16'h5329, 16'h52CD,
		16'h5273, 16'h5218, 16'h51BE, 16'h5164, 16'h510B, 16'h50B2, 16'h5059, 16'h5001,
		16'h4FA9, 16'h4F51, 16'h4EFA, 16'h4EA3, 16'h4E4C, 16'h4DF5, 16'h4D9F, 16'h4D48,
		16'h4CF3, 16'h4C9D, 16'h4C47, 16'h4BF2, 16'h4B9D, 16'h4B48, 16'h4AF4, 16'h4A9F,
		16'h4A4B, 16'h49F7, 16'h49A3, 16'h494F, 16'h48FC, 16'h48A8, 16'h4855, 16'h4802,
		16'h47AF, 16'h475C, 16'h4709, 16'h46B7, 16'h4664, 16'h4612, 16'h45BF, 16'h456D,
		16'h451B, 16'h44C9, 16'h4477, 16'h4425, 16'h43D3, 16'h4381, 16'h432F, 16'h42DD,
		16'h428C, 16'h423A, 16'h41E9, 16'h4197, 16'h4146, 16'h40F4, 16'h40A2, 16'h4051,
		16'h3FFF, 16'h3FAE, 16'h3F5D, 16'h3F0B, 16'h3EB9, 16'h3E68, 16'h3E16, 16'h3DC5,
		16'h3D73, 16'h3D22, 16'h3CD0, 16'h3C7E, 16'h3C2C, 16'h3BDA, 16'h3B88, 16'h3B36,
		16'h3AE4, 16'h3A92, 16'h3A40, 16'h39ED, 16'h399B, 16'h3948, 16'h38F6, 16'h38A3,
		16'h3850, 16'h37FD, 16'h37AA, 16'h3757, 16'h3703, 16'h36B0, 16'h365C, 16'h3608,
		16'h35B4, 16'h3560, 16'h350B, 16'h34B7, 16'h3462, 16'h340D, 16'h33B8, 16'h3362,
		16'h330C, 16'h32B7, 16'h3260, 16'h320A, 16'h31B3, 16'h315C, 16'h3105, 16'h30AE,
		16'h3056, 16'h2FFE, 16'h2FA6, 16'h2F4D, 16'h2EF4, 16'h2E9B, 16'h2E41, 16'h2DE7,
		16'h2D8C, 16'h2D32, 16'h2CD6, 16'h2C7B, 16'h2C1F, 16'h2BC2, 16'h2B65, 16'h2B08,
		16'h2AAA, 16'h2A4C, 16'h29ED, 16'h298E, 16'h292E, 16'h28CD, 16'h286C, 16'h280B,
		16'h27A8, 16'h2745, 16'h26E2, 16'h267E, 16'h2619, 16'h25B3, 16'h254D, 16'h24E6,
		16'h247E, 16'h2415, 16'h23AB, 16'h2341, 16'h22D5, 16'h2269, 16'h21FB, 16'h218C,
		16'h211D, 16'h20AC, 16'h203A, 16'h1FC7, 16'h1F52, 16'h1EDC, 16'h1E65, 16'h1DEC,
		16'h1D72, 16'h1CF6, 16'h1C78, 16'h1BF8, 16'h1B77, 16'h1AF3, 16'h1A6E, 16'h19E6,
		16'h195B, 16'h18CE, 16'h183E, 16'h17AB, 16'h1715, 16'h167B, 16'h15DE, 16'h153D,
		16'h1497, 16'h13EC, 16'h133B, 16'h1285, 16'h11C8, 16'h1103, 16'h1036, 16'h0F5E,
		16'h0E7B, 16'h0D89, 16'h0C86, 16'h0B6C, 16'h0A36, 16'h08D6, 16'h0736, 16'h0518,
		16'h0000
	};

	localparam logic [15:0] ATAN_ROM [257] = '{
		16'h0000, 16'h0028, 16'h0051, 16'h007A, 16'h00A2, 16'h00CB, 16'h00F4, 16'h011D,
		16'h0145, 16'h016E, 16'h0197, 16'h01BF, 16'h01E8, 16'h0211, 16'h0239, 16'h0262,
		16'h028B, 16'h02B3, 16'h02DC, 16'h0304, 16'h032D, 16'h0355, 16'h037E, 16'h03A6,
		16'h03CE, 16'h03F7, 16'h041F, 16'h0448, 16'h0470, 16'h0498, 16'h04C0, 16'h04E8,
		16'h0511, 16'h0539, 16'h0561, 16'h0589, 16'h05B1, 16'h05D9, 16'h0601, 16'h0628,
		16'h0650, 16'h0678, 16'h06A0, 16'h06C7, 16'h06EF, 16'h0716, 16'h073E, 16'h0765,
		16'h078D, 16'h07B4, 16'h07DB, 16'h0803, 16'h082A, 16'h0851, 16'h0878, 16'h089F,
		16'h08C6, 16'h08ED, 16'h0913, 16'h093A, 16'h0961, 16'h0987, 16'h09AE, 16'h09D4,
		16'h09FB, 16'h0A21, 16'h0A47, 16'h0A6D, 16'h0A94, 16'h0ABA, 16'h0AE0, 16'h0B05,
		16'h0B2B, 16'h0B51, 16'h0B77, 16'h0B9C, 16'h0BC2, 16'h0BE7, 16'h0C0C, 16'h0C32,
		16'h0C57, 16'h0C7C, 16'h0CA1, 16'h0CC6, 16'h0CEB, 16'h0D0F, 16'h0D34, 16'h0D58,
		16'h0D7D, 16'h0DA1, 16'h0DC6, 16'h0DEA, 16'h0E0E, 16'h0E32, 16'h0E56, 16'h0E7A,
		16'h0E9E, 16'h0EC1, 16'h0EE5, 16'h0F08, 16'h0F2C, 16'h0F4F, 16'h0F72, 16'h0F95,
		16'h0FB8, 16'h0FDB, 16'h0FFE, 16'h1021, 16'h1044, 16'h1066, 16'h1089, 16'h10AB,
		16'h10CD, 16'h10EF, 16'h1111, 16'h1133, 16'h1155, 16'h1177, 16'h1199, 16'h11BA,
		16'h11DC, 16'h11FD, 16'h121E, 16'h123F, 16'h1260, 16'h1281, 16'h12A2, 16'h12C3,
		16'h12E4, 16'h1304, 16'h1325, 16'h1345, 16'h1365, 16'h1385, 16'h13A5, 16'h13C5,
		16'h13E5, 16'h1405, 16'h1424, 16'h1444, 16'h1463, 16'h1483, 16'h14A2, 16'h14C1,
		16'h14E0, 16'h14FF, 16'h151E, 16'h153C, 16'h155B, 16'h1579, 16'h1598, 16'h15B6,
		16'h15D4, 16'h15F2, 16'h1610, 16'h162E, 16'h164C, 16'h166A, 16'h1687, 16'h16A5,
		16'h16C2, 16'h16DF, 16'h16FC, 16'h1719, 16'h1736, 16'h1753, 16'h1770, 16'h178C,
		16'h17A9, 16'h17C5, 16'h17E2, 16'h17FE, 16'h181A, 16'h1836, 16'h1852, 16'h186E,
		16'h188A, 16'h18A5, 16'h18C1, 16'h18DC, 16'h18F7, 16'h1913, 16'h192E, 16'h1949,
		16'h1964, 16'h197F, 16'h1999, 16'h19B4, 16'h19CE, 16'h19E9, 16'h1A03, 16'h1A1D,
		16'h1A37, 16'h1A51, 16'h1A6B, 16'h1A85, 16'h1A9F, 16'h1AB9, 16'h1AD2, 16'h1AEC,
		16'h1B05, 16'h1B1E, 16'h1B37, 16'h1B50, 16'h1B69, 16'h1B82, 16'h1B9B, 16'h1BB4,
		16'h1BCC, 16'h1BE5, 16'h1BFD, 16'h1C16, 16'h1C2E, 16'h1C46, 16'h1C5E, 16'h1C76,
		16'h1C8E, 16'h1CA5, 16'h1CBD, 16'h1CD5, 16'h1CEC, 16'h1D04, 16'h1D1B, 16'h1D32,
		16'h1D49, 16'h1D60, 16'h1D77, 16'h1D8E, 16'h1DA5, 16'h1DBB, 16'h1DD2, 16'h1DE9,
		16'h1DFF, 16'h1E15, 16'h1E2C, 16'h1E42, 16'h1E58, 16'h1E6E, 16'h1E84, 16'h1E99,
		16'h1EAF, 16'h1EC5, 16'h1EDA, 16'h1EF0, 16'h1F05, 16'h1F1B, 16'h1F30, 16'h1F45,
		16'h1F5A, 16'h1F6F, 16'h1F84, 16'h1F99, 16'h1FAD, 16'h1FC2, 16'h1FD7, 16'h1FEB,
		16'h2000
	};

	// sample i of the table picked by func, sign extended
	function automatic logic signed [16:0] rom_entry(input logic [2:0] func,
			input logic [8:0] idx);
		logic [7:0]  k;
		logic [6:0]  j;
		logic [7:0]  mir;
		logic [15:0] q;
		logic signed [16:0] r;
		k   = idx[7:0] + ((func == FN_COS) ? 8'd64 : 8'd0);
		j   = k[6:0];
		mir = 8'd128 - {1'b0, j};
		q   = (j <= 7'd64) ? SINE_Q[j] : SINE_Q[mir[6:0]];
		r   = 17'sd0;
		case (func)
			FN_SIN, FN_COS: r = k[7] ? -$signed({1'b0, q}) : $signed({1'b0, q});
			FN_ASIN:        r = $signed({ASIN_ROM[idx][15], ASIN_ROM[idx]});
			FN_ACOS:        r = $signed({ACOS_ROM[idx][15], ACOS_ROM[idx]});
			FN_ATAN:        r = $signed({ATAN_ROM[idx][15], ATAN_ROM[idx]});
			default:        r = 17'sd0;
		endcase
		return r;
	endfunction

endpackage

### hdl/ftu_div.sv
// ----------------------------------------------------------------------------
// ftu_div
// pipelined restoring divider: one quotient bit per stage, elastic handshake
// ----------------------------------------------------------------------------
`include "fixed_point_trig_unit_top_defines.svh"

module ftu_div import ftu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  ftu_item_t in_item,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic      out_valid,
	input  logic      out_ready,
	output ftu_item_t out_item
);

	logic        vld_q  [DIV_STAGES];
	ftu_item_t   item_q [DIV_STAGES];
	logic [31:0] rem_q  [DIV_STAGES];
	logic [31:0] den_q  [DIV_STAGES];
	logic [15:0] quo_q  [DIV_STAGES];
	logic        rdy    [DIV_STAGES];

	always_comb begin
		rdy[DIV_STAGES-1] = !vld_q[DIV_STAGES-1] || out_ready;
		for (int k = DIV_STAGES - 2; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic        src_v;
		ftu_item_t   src_item;
		logic [31:0] src_rem;
		logic [31:0] src_den;
		logic [15:0] src_quo;
		logic [32:0] shifted;
		logic        ge;

		if (k == 0) begin : g_first
			assign src_v    = in_valid;
			assign src_item = in_item;
			assign src_rem  = num;
			assign src_den  = den;
			assign src_quo  = '0;
		end else begin : g_next
			assign src_v    = vld_q[k-1];
			assign src_item = item_q[k-1];
			assign src_rem  = rem_q[k-1];
			assign src_den  = den_q[k-1];
			assign src_quo  = quo_q[k-1];
		end

		assign shifted = {src_rem, 1'b0};
		assign ge      = shifted >= {1'b0, src_den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_q[k] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && src_v) begin
				item_q[k] <= src_item;
				den_q[k]  <= src_den;
				rem_q[k]  <= ge ? 32'(shifted - {1'b0, src_den}) : shifted[31:0];
				quo_q[k]  <= {src_quo[14:0], ge};
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_q[DIV_STAGES-1];

	always_comb begin
		out_item = item_q[DIV_STAGES-1];
		if (item_q[DIV_STAGES-1].func == FN_ATAN) begin
			out_item.arg = quo_q[DIV_STAGES-1];
		end
	end

	// partial remainder stays below the divisor for a real ratio
	`FTU_ASSERT_NOW(a_rem_below_den, vld_q[DIV_STAGES-1] && item_q[DIV_STAGES-1].func == FN_ATAN && !item_q[DIV_STAGES-1].special, rem_q[DIV_STAGES-1] < den_q[DIV_STAGES-1], "divider remainder not below divisor")

endmodule

### hdl/ftu_lerp.sv
// ----------------------------------------------------------------------------
// ftu_lerp
// table read, linear interpolation and result formatting, three stages
// ----------------------------------------------------------------------------
`include "fixed_point_trig_unit_top_defines.svh"

module ftu_lerp import ftu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  ftu_item_t   in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [16:0] result_value
);

	logic rdy_s1, rdy_s2, rdy_s3;
	logic v_s1, v_s2, v_s3;
	ftu_item_t item_s1, item_s2;
	logic [15:0] base_s1;
	logic signed [17:0] delta_s1;
	logic [16:0] res_s3;
	logic [15:0] sum_s2;

	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// stage 1: two neighboring samples
	logic signed [16:0] smp_lo, smp_hi;
	assign smp_lo = rom_entry(in_item.func, {1'b0, in_item.arg[15:8]});
	assign smp_hi = rom_entry(in_item.func, 9'({1'b0, in_item.arg[15:8]} + 9'd1));

	// stage 2: product floored to whole samples
	logic signed [26:0] prod;
	logic signed [26:0] prod_r;
	assign prod   = delta_s1 * $signed({1'b0, item_s1.arg[7:0]});
	assign prod_r = prod >>> 8;

	// stage 3: output format
	logic [16:0] fmt;
	always_comb begin
		fmt = '0;
		case (item_s2.func) inside
			FN_SIN, FN_COS:   fmt = {sum_s2, 1'b0};
			FN_ASIN, FN_ACOS: fmt = {1'b0, sum_s2};
			FN_ATAN: begin
				if (item_s2.special) begin
					fmt = {1'b0, item_s2.spec_val};
				end else if (OCT_SUB[item_s2.code]) begin
					fmt = {1'b0, 16'(OCT_BASE[item_s2.code] - sum_s2)};
				end else begin
					fmt = {1'b0, 16'(OCT_BASE[item_s2.code] + sum_s2)};
				end
			end
			default: fmt = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			item_s1  <= in_item;
			base_s1  <= smp_lo[15:0];
			delta_s1 <= 18'(smp_hi) - 18'(smp_lo);
		end
		if (rdy_s2 && v_s1) begin
			item_s2 <= item_s1;
			sum_s2  <= base_s1 + prod_r[15:0];
		end
		if (rdy_s3 && v_s2) begin
			res_s3 <= fmt;
		end
	end

	assign out_valid    = v_s3;
	assign result_value = res_s3;

	`FTU_ASSERT_NEXT(a_sin_even, rdy_s3 && v_s2 && (item_s2.func == FN_SIN || item_s2.func == FN_COS), !res_s3[0], "sine or cosine result not even")
	`FTU_ASSERT_NEXT(a_s2_hold, v_s2 && !rdy_s3, v_s2 && $stable(sum_s2), "interpolation stage lost its beat")

endmodule

### hdl/fixed_point_trig_unit_top.sv
// ----------------------------------------------------------------------------
// fixed_point_trig_unit_top
// sine, cosine, arcsine, arccosine and atan2 by table lookup and interpolation
// ----------------------------------------------------------------------------
// Usage:
//   input channel in_valid/in_ready carries func, operand_a, operand_b;
//   output channel out_valid/out_ready carries result_value.
//   func selects sine, cosine (angle in operand_a[15:0]), arcsine, arccosine
//   (16.16 in operand_a) or atan2 (y in operand_a, x in operand_b).
//   The path runs through one operand stage, 16 divider stages (one quotient
//   bit each, set by the atan2 ratio) and three interpolation stages.
//   Throughput is one beat per cycle while out_ready stays high; every function takes the same path so
//   results leave in input order.
//   Each stage holds its beat only while the next stage holds its own, so a stalled
//   receiver fills the pipe and in_ready drops only once all 20 stages hold
//   beats; bubbles close up while the output waits.
//   Reset clears all stage valid flags; no result is pending after reset.
// ----------------------------------------------------------------------------
`include "fixed_point_trig_unit_top_defines.svh"

module fixed_point_trig_unit_top import ftu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [16:0] result_value
);

	logic v_s1;
	ftu_item_t item_s1, item_d;
	logic [31:0] num_s1, den_s1;
	logic div_in_ready, div_out_valid, lerp_in_ready;

	// operand preparation
	ftu_item_t pre;
	logic [31:0] ay, ax, num_c, den_c;
	logic x_pos, y_pos, x_neg, y_neg;
	logic signed [16:0] clamp_v;
	logic [16:0] off_v;

	always_comb begin
		ay    = operand_a[31] ? 32'(-operand_a) : operand_a;
		ax    = operand_b[31] ? 32'(-operand_b) : operand_b;
		x_neg = operand_b[31];
		y_neg = operand_a[31];
		x_pos = !operand_b[31] && (operand_b != 32'sd0);
		y_pos = !operand_a[31] && (operand_a != 32'sd0);
		num_c = (ax > ay) ? ay : ax;
		den_c = (ax > ay) ? ax : ay;

		if (operand_a < -32'sd65536) begin
			clamp_v = -17'sd65536;
		end else if (operand_a > 32'sd65535) begin
			clamp_v = 17'sd65535;
		end else begin
			clamp_v = operand_a[16:0];
		end
		off_v = 17'(clamp_v) + 17'h10000;

		pre          = '0;
		pre.func     = func;
		pre.code     = {ax > ay, y_pos, x_pos};
		case (func)
			FN_SIN, FN_COS:   pre.arg = operand_a[15:0];
			FN_ASIN, FN_ACOS: pre.arg = off_v[16:1];
			FN_ATAN: begin
				// equal magnitudes land on a diagonal, or on the origin
				if (ax == ay) begin
					pre.special = 1'b1;
					if (x_pos && y_neg)      pre.spec_val = 16'hE000;
					else if (x_neg && y_neg) pre.spec_val = 16'hA000;
					else if (x_neg && y_pos) pre.spec_val = 16'h6000;
					else if (x_pos && y_pos) pre.spec_val = 16'h2000;
					else                     pre.spec_val = 16'h0000;
				end
			end
			default: pre.special = 1'b1;
		endcase
	end

	assign in_ready = !v_s1 || div_in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= pre;
			num_s1  <= num_c;
			den_s1  <= den_c;
		end
	end

	ftu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1),
		.in_ready (div_in_ready),
		.in_item  (item_s1),
		.num      (num_s1),
		.den      (den_s1),
		.out_valid(div_out_valid),
		.out_ready(lerp_in_ready),
		.out_item (item_d)
	);

	ftu_lerp u_lerp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (div_out_valid),
		.in_ready    (lerp_in_ready),
		.in_item     (item_d),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_value(result_value)
	);

	`FTU_ASSERT_NEXT(a_s1_hold, v_s1 && !div_in_ready, v_s1 && $stable(item_s1) && $stable(den_s1), "operand stage changed while stalled")

endmodule
